FILE: src/encoder_multiturn_tracker_top_defines.svh
// Shared assertion macros for the tracker checkers.
`ifndef ENCODER_MULTITURN_TRACKER_TOP_DEFINES_SVH
`define ENCODER_MULTITURN_TRACKER_TOP_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define EMT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define EMT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/emt_pkg.sv
package emt_pkg;

    // Ring depth; the mean is taken by an arithmetic shift, so keep it a power of two.
    localparam int RATE_WINDOW = 8;
    localparam int HIST_SH     = $clog2(RATE_WINDOW);
    localparam int HIST_AW     = (RATE_WINDOW > 1) ? $clog2(RATE_WINDOW) : 1;

    localparam int CNT_W  = 13;
    localparam int STEP_W = 14;
    localparam int SUM_W  = STEP_W + HIST_SH;
    localparam int RATE_W = 16;

    localparam int TURN_COUNTS    = 8192;
    localparam int WRAP_HALF      = 4096;
    localparam int ALIGN_TOL      = 4000;
    localparam int CAPTURE_FRAMES = 5;
    localparam int PRESET_FRAMES  = 2;
    localparam int ALIGN_FRAMES   = 10;
    localparam int FC_MAX         = 15;

    typedef enum logic [0:0] {
        MODE_CAPTURE  = 1'b0,
        MODE_REGISTER = 1'b1
    } t_mode;

    typedef enum logic [0:0] {
        CFG_MOTOR_MODE  = 1'b0,
        CFG_ZERO_OFFSET = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                     push;
        logic signed [STEP_W-1:0] step;
    } t_ring_req;

endpackage

FILE: src/encoder_multiturn_tracker_top.sv
// Channel   | Signals                                      | Direction
// ----------+----------------------------------------------+----------
// frame in  | i_valid, o_stall, shaft/speed/current/temp   | in
// result    | o_valid, i_stall, count/angle/rate/held/bias | out
// config    | i_cfg_wr_en, i_cfg_idx, i_cfg_wdata          | in
//
// One frame per cycle unless o_stall is high; the step-history ring RAM is read
// one frame ahead at the next slot, so the running sum never waits. Results sit
// in an output register; a new frame is taken while that register drains. Reset
// is synchronous; the ring uses per-slot valid bits, no clear pass. A stalled
// result holds every field, and o_stall rises only while it is held.
module encoder_multiturn_tracker_top import emt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [0:0]               i_cfg_idx,
    input  logic [CNT_W-1:0]         i_cfg_wdata,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [CNT_W-1:0]         i_shaft_count,
    input  logic signed [15:0]       i_speed_word,
    input  logic signed [15:0]       i_current_word,
    input  logic [7:0]               i_temp_byte,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [29:0]       o_total_count,
    output logic signed [34:0]       o_angle_fine,
    output logic signed [STEP_W-1:0] o_step_rate,
    output logic signed [RATE_W-1:0] o_smoothed_rate,
    output logic signed [15:0]       o_speed_out,
    output logic signed [15:0]       o_current_out,
    output logic [7:0]               o_temp_out,
    output logic signed [15:0]       o_turns,
    output logic signed [14:0]       o_zero_bias,
    output logic                     o_calibrating
);

    t_mode                     r_mode;
    logic [CNT_W-1:0]          r_zero_off;
    logic [3:0]                r_fc;
    logic [3:0]                n_fc;
    logic [CNT_W-1:0]          r_prev;
    logic signed [15:0]        r_turns;
    logic signed [15:0]        n_turns;
    logic signed [14:0]        r_bias;
    logic signed [14:0]        n_bias;
    logic signed [15:0]        r_speed;
    logic signed [15:0]        r_current;
    logic [7:0]                r_temp;
    logic signed [RATE_W-1:0]  r_smooth;
    logic signed [STEP_W-1:0]  r_step;
    logic                      r_calib;
    logic                      r_out_valid;

    logic                      accept;
    logic                      capture;
    logic signed [STEP_W-1:0]  diff;
    logic                      wrap_up;
    logic                      wrap_dn;
    logic signed [STEP_W-1:0]  step;
    logic signed [29:0]        total_new;
    logic signed [14:0]        zo_s;
    logic signed [14:0]        bias_base;
    logic signed [31:0]        align_d;
    logic signed [14:0]        bias_reg_mode;
    logic signed [RATE_W-1:0]  ring_mean;
    t_ring_req                 ring_req;
    logic signed [34:0]        rel;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_fc    = (r_fc == 4'(FC_MAX)) ? r_fc : r_fc + 4'd1;
        capture = (r_mode == MODE_CAPTURE) && (n_fc <= 4'(CAPTURE_FRAMES));

        diff    = {1'b0, i_shaft_count} - {1'b0, r_prev};
        wrap_up = diff < -WRAP_HALF;
        wrap_dn = diff > WRAP_HALF;
        if (wrap_up) begin
            step = diff + STEP_W'(TURN_COUNTS);
        end else if (wrap_dn) begin
            step = diff - STEP_W'(TURN_COUNTS);
        end else begin
            step = diff;
        end

        n_turns = r_turns;
        if (!capture) begin
            if (wrap_up) begin
                n_turns = r_turns + 16'sd1;
            end else if (wrap_dn) begin
                n_turns = r_turns - 16'sd1;
            end
        end
        // turns * 8192 leaves the low 13 bits free for the shaft count
        total_new = {n_turns[15], n_turns, i_shaft_count};

        zo_s      = {2'b00, r_zero_off};
        bias_base = (n_fc <= 4'(PRESET_FRAMES)) ? zo_s : r_bias;
        align_d   = {{17{bias_base[14]}}, bias_base} - {{2{total_new[29]}}, total_new};
        bias_reg_mode = bias_base;
        if (n_fc <= 4'(ALIGN_FRAMES)) begin
            if (align_d < -ALIGN_TOL) begin
                bias_reg_mode = zo_s + 15'(TURN_COUNTS);
            end else if (align_d > ALIGN_TOL) begin
                bias_reg_mode = zo_s - 15'(TURN_COUNTS);
            end
        end

        if (r_mode == MODE_REGISTER) begin
            n_bias = bias_reg_mode;
        end else if (capture) begin
            n_bias = {2'b00, i_shaft_count};
        end else begin
            n_bias = r_bias;
        end

        ring_req.push = accept && (r_mode == MODE_CAPTURE) && !capture;
        ring_req.step = step;
    end

    emt_ring u_ring (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (ring_req),
        .o_mean (ring_mean)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_CAPTURE;
            r_zero_off <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_MOTOR_MODE:  r_mode     <= t_mode'(i_cfg_wdata[0]);
                CFG_ZERO_OFFSET: r_zero_off <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc        <= '0;
            r_prev      <= '0;
            r_turns     <= '0;
            r_bias      <= '0;
            r_speed     <= '0;
            r_current   <= '0;
            r_temp      <= '0;
            r_smooth    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_fc    <= n_fc;
                r_prev  <= i_shaft_count;
                r_turns <= n_turns;
                r_bias  <= n_bias;
                if (r_mode == MODE_REGISTER) begin
                    r_smooth <= i_speed_word;
                    r_temp   <= i_temp_byte;
                end else if (!capture) begin
                    r_smooth  <= ring_mean;
                    r_speed   <= i_speed_word;
                    r_current <= i_current_word;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_step  <= capture ? '0 : step;
            r_calib <= capture;
        end
    end

    // State only moves on a transfer in, which the output register gates,
    // so held state doubles as result payload.
    assign o_total_count = {r_turns[15], r_turns, r_prev};
    assign rel = {{5{o_total_count[29]}}, o_total_count} - {{20{r_bias[14]}}, r_bias};
    // x * 45 = 32x + 8x + 4x + x
    assign o_angle_fine    = (rel <<< 5) + (rel <<< 3) + (rel <<< 2) + rel;
    assign o_valid         = r_out_valid;
    assign o_step_rate     = r_step;
    assign o_smoothed_rate = r_smooth;
    assign o_speed_out     = r_speed;
    assign o_current_out   = r_current;
    assign o_temp_out      = r_temp;
    assign o_turns         = r_turns;
    assign o_zero_bias     = r_bias;
    assign o_calibrating   = r_calib;

endmodule

FILE: src/emt_ram.sv
module emt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: src/emt_ring.sv
module emt_ring import emt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ring_req                i_req,
    output logic signed [RATE_W-1:0] o_mean
);

    logic [HIST_AW-1:0]      r_idx;
    logic [HIST_AW-1:0]      n_idx;
    logic [RATE_WINDOW-1:0]  r_valid;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic                    r_fwd_hit;
    logic [STEP_W-1:0]       r_fwd_data;
    logic [STEP_W-1:0]       rd_data;
    logic [STEP_W-1:0]       old_step;
    logic signed [SUM_W-1:0] old_ext;
    logic signed [SUM_W-1:0] step_ext;
    logic signed [SUM_W-1:0] sum_adj;
    logic signed [SUM_W-1:0] mean_full;

    // Read port always points at the slot the next push will replace.
    emt_ram #(
        .WIDTH(STEP_W),
        .DEPTH(RATE_WINDOW)
    ) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (i_req.push),
        .i_waddr(r_idx),
        .i_wdata(i_req.step),
        .i_raddr(n_idx),
        .o_rdata(rd_data)
    );

    always_comb begin
        n_idx = r_idx;
        if (i_req.push) begin
            n_idx = (r_idx == HIST_AW'(RATE_WINDOW - 1)) ? '0 : r_idx + 1'b1;
        end
    end

    // Same-slot write and read on one edge: take the written value.
    // A slot never written since reset reads as zero.
    always_comb begin
        old_step  = r_fwd_hit ? r_fwd_data : (r_valid[r_idx] ? rd_data : '0);
        old_ext   = {{(SUM_W-STEP_W){old_step[STEP_W-1]}}, old_step};
        step_ext  = {{(SUM_W-STEP_W){i_req.step[STEP_W-1]}}, i_req.step};
        n_sum     = r_sum + step_ext - old_ext;
        // truncate toward zero
        sum_adj   = n_sum + ((n_sum < 0) ? SUM_W'(RATE_WINDOW - 1) : SUM_W'(0));
        mean_full = sum_adj >>> HIST_SH;
        o_mean    = mean_full[RATE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_sum     <= '0;
            r_valid   <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= i_req.push && (n_idx == r_idx);
            if (i_req.push) begin
                r_idx          <= n_idx;
                r_sum          <= n_sum;
                r_valid[r_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= i_req.step;
    end

endmodule

FILE: src/emt_checker.sv
`include "encoder_multiturn_tracker_top_defines.svh"

module emt_checker import emt_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_stall,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic signed [29:0]       o_total_count,
    input logic signed [34:0]       o_angle_fine,
    input logic signed [STEP_W-1:0] o_step_rate,
    input logic signed [15:0]       o_turns,
    input logic                     o_calibrating
);

    logic        out_full;
    logic        calib_out;
    logic        turns_match;
    logic [65:0] out_word;

    assign out_full    = o_valid && i_stall;
    assign calib_out   = o_valid && o_calibrating;
    assign turns_match = o_total_count[28:13] == o_turns;
    // valid rides along, so a stable word also keeps the result presented
    assign out_word    = {o_valid, o_total_count, o_angle_fine};

    `EMT_ASSERT_ALWAYS(a_idle_after_reset, i_clk, !i_rst_n |=> !o_valid, "valid out of reset")
    `EMT_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, o_stall |-> out_full, "needless stall")
    `EMT_ASSERT(a_hold_on_stall, i_clk, i_rst_n, out_full |=> $stable(out_word), "result moved")
    `EMT_ASSERT(a_calib_no_step, i_clk, i_rst_n, calib_out |-> o_step_rate == '0, "capture step")
    `EMT_ASSERT(a_turns_in_count, i_clk, i_rst_n, o_valid |-> turns_match, "turns mismatch")

endmodule

bind encoder_multiturn_tracker_top emt_checker u_emt_checker (.*);
